// ===== rtl/cpt_pkg.sv =====
// Shared types and codes for the closest-point-on-triangle pipeline.
`default_nettype none

package cpt_pkg;

    // Coordinate width of every input and result coordinate.
    localparam int CPT_W = 24;

    // Region codes carried in the result.
    localparam logic [2:0] RGN_VTX_A    = 3'd0;
    localparam logic [2:0] RGN_VTX_B    = 3'd1;
    localparam logic [2:0] RGN_VTX_C    = 3'd2;
    localparam logic [2:0] RGN_EDGE_AB  = 3'd3;
    localparam logic [2:0] RGN_EDGE_BC  = 3'd4;
    localparam logic [2:0] RGN_EDGE_AC  = 3'd5;
    localparam logic [2:0] RGN_INTERIOR = 3'd6;

    typedef struct packed {
        logic signed [CPT_W-1:0] ax;
        logic signed [CPT_W-1:0] ay;
        logic signed [CPT_W-1:0] az;
        logic signed [CPT_W-1:0] bx;
        logic signed [CPT_W-1:0] by;
        logic signed [CPT_W-1:0] bz;
        logic signed [CPT_W-1:0] cx;
        logic signed [CPT_W-1:0] cy;
        logic signed [CPT_W-1:0] cz;
        logic signed [CPT_W-1:0] px;
        logic signed [CPT_W-1:0] py;
        logic signed [CPT_W-1:0] pz;
    } t_cpt_in;

    typedef struct packed {
        logic signed [CPT_W-1:0] qx;
        logic signed [CPT_W-1:0] qy;
        logic signed [CPT_W-1:0] qz;
        logic [2:0]              region;
        logic                    degenerate;
    } t_cpt_out;

endpackage

`default_nettype wire

// ===== rtl/closest_point_on_triangle.sv =====
// Closest point on a triangle to a query point, fully pipelined.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_item   (t_cpt_in)
//   result   out        o_valid / i_stall   o_result (t_cpt_out)
//
// One transaction enters per cycle while o_stall is low, and each one leaves through
// the registered output stage. Most of the pipeline depth comes from the restoring divider,
// which resolves one quotient bit per stage for CPT_W + 2 bits.
// Reset clears only the valid bits of the pipeline.
// A stall holds every stage at once, so nothing is dropped or repeated.
`default_nettype none

module closest_point_on_triangle import cpt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_cpt_in  i_item,
    output logic     o_valid,
    input  logic     i_stall,
    output t_cpt_out o_result
);

    localparam int W   = CPT_W;
    localparam int D   = W + 1;          // coordinate difference
    localparam int P   = 2 * D;          // product of two differences
    localparam int C   = P + 1;          // cross product component
    localparam int DT  = P + 2;          // dot product of differences
    localparam int V   = 2 * C + 2;      // barycentric volume terms
    localparam int DW  = V + 2;          // divisor
    localparam int NW  = D + V + 2;      // signed numerator
    localparam int NN  = NW + 1;         // rounded dividend
    localparam int QB  = W + 2;          // quotient bits
    localparam int RW  = DW + QB + 2;    // divider remainder
    localparam int DS0 = 13;
    localparam int DSN = 12 + QB;
    localparam int NS  = 13 + QB;

    localparam int DI_SN = 0;
    localparam int DI_SD = 1;
    localparam int DI_TN = 2;
    localparam int DI_TD = 3;
    localparam int DI_UN = 4;
    localparam int DI_UD = 5;
    localparam int VI_A  = 0;
    localparam int VI_B  = 1;
    localparam int VI_C  = 2;

    localparam logic [QB-1:0]         QMAX   = {1'b1, {(QB-1){1'b0}}};
    localparam logic signed [W+3:0]   SAT_HI = {5'b00000, {(W-1){1'b1}}};
    localparam logic signed [W+3:0]   SAT_LO = {5'b11111, {(W-1){1'b0}}};

    logic en;
    logic [NS:1] r_vld;

    assign en      = !r_vld[NS] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-1:1], i_valid};
        end
    end

    // ---------------------------------------------------------------- stage 1
    logic signed [W-1:0] in_pt [4][3];

    always_comb begin
        in_pt[0][0] = i_item.ax;
        in_pt[0][1] = i_item.ay;
        in_pt[0][2] = i_item.az;
        in_pt[1][0] = i_item.bx;
        in_pt[1][1] = i_item.by;
        in_pt[1][2] = i_item.bz;
        in_pt[2][0] = i_item.cx;
        in_pt[2][1] = i_item.cy;
        in_pt[2][2] = i_item.cz;
        in_pt[3][0] = i_item.px;
        in_pt[3][1] = i_item.py;
        in_pt[3][2] = i_item.pz;
    end

    logic signed [D-1:0] r_ab [3];
    logic signed [D-1:0] r_ac [3];
    logic signed [D-1:0] r_bc [3];
    logic signed [D-1:0] r_pa [3];
    logic signed [D-1:0] r_pb [3];
    logic signed [D-1:0] r_pc [3];
    logic signed [W-1:0] r_vtx [1:8][3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_ab[k] <= D'(in_pt[1][k]) - D'(in_pt[0][k]);
                r_ac[k] <= D'(in_pt[2][k]) - D'(in_pt[0][k]);
                r_bc[k] <= D'(in_pt[2][k]) - D'(in_pt[1][k]);
                r_pa[k] <= D'(in_pt[3][k]) - D'(in_pt[0][k]);
                r_pb[k] <= D'(in_pt[3][k]) - D'(in_pt[1][k]);
                r_pc[k] <= D'(in_pt[3][k]) - D'(in_pt[2][k]);
                for (int v = 0; v < 3; v++) begin
                    r_vtx[1][v][k] <= in_pt[v][k];
                    for (int s = 2; s <= 7; s++) begin
                        r_vtx[s][v][k] <= r_vtx[s-1][v][k];
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Dot terms: s nom/denom on ab, t on ac, u on bc. Cross pairs: the normal
    // ab x ac, then pb x pc, pc x pa and pa x pb for the weights of a, b, c.
    logic signed [D-1:0] dot_u [6][3];
    logic signed [D-1:0] dot_v [6][3];
    logic signed [D-1:0] crs_u [4][3];
    logic signed [D-1:0] crs_v [4][3];
    logic signed [P-1:0] r_pd [6][3];
    logic signed [P-1:0] r_cp [4][3][2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dot_u[DI_SN][k] = r_pa[k];
            dot_v[DI_SN][k] = r_ab[k];
            dot_u[DI_SD][k] = r_pb[k];
            dot_v[DI_SD][k] = r_ab[k];
            dot_u[DI_TN][k] = r_pa[k];
            dot_v[DI_TN][k] = r_ac[k];
            dot_u[DI_TD][k] = r_pc[k];
            dot_v[DI_TD][k] = r_ac[k];
            dot_u[DI_UN][k] = r_pb[k];
            dot_v[DI_UN][k] = r_bc[k];
            dot_u[DI_UD][k] = r_pc[k];
            dot_v[DI_UD][k] = r_bc[k];
            crs_u[0][k] = r_ab[k];
            crs_v[0][k] = r_ac[k];
            crs_u[1][k] = r_pb[k];
            crs_v[1][k] = r_pc[k];
            crs_u[2][k] = r_pc[k];
            crs_v[2][k] = r_pa[k];
            crs_u[3][k] = r_pa[k];
            crs_v[3][k] = r_pb[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int d = 0; d < 6; d++) begin
                    r_pd[d][k] <= dot_u[d][k] * dot_v[d][k];
                end
                for (int s = 0; s < 4; s++) begin
                    r_cp[s][k][0] <= crs_u[s][(k == 2) ? 0 : k + 1]
                                   * crs_v[s][(k == 0) ? 2 : k - 1];
                    r_cp[s][k][1] <= crs_u[s][(k == 0) ? 2 : k - 1]
                                   * crs_v[s][(k == 2) ? 0 : k + 1];
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic signed [DT-1:0] n_dot3 [6];
    logic signed [DT-1:0] r_dot [3:7][6];
    logic signed [C-1:0]  r_crs [4][3];

    // The denominators use (a - b) = -(b - a), so those sums are negated.
    always_comb begin
        for (int d = 0; d < 6; d++) begin
            n_dot3[d] = DT'(r_pd[d][0]) + DT'(r_pd[d][1]) + DT'(r_pd[d][2]);
            if (d == DI_SD || d == DI_TD || d == DI_UD) begin
                n_dot3[d] = -n_dot3[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < 6; d++) begin
                r_dot[3][d] <= n_dot3[d];
                for (int s = 4; s <= 7; s++) begin
                    r_dot[s][d] <= r_dot[s-1][d];
                end
            end
            for (int s = 0; s < 4; s++) begin
                for (int k = 0; k < 3; k++) begin
                    r_crs[s][k] <= C'(r_cp[s][k][0]) - C'(r_cp[s][k][1]);
                end
            end
        end
    end

    // ------------------------------------------------------ stages 4 and 5
    logic signed [2*C-1:0] w_tp [3][3];

    for (genvar t = 0; t < 3; t++) begin : g_vol
        for (genvar k = 0; k < 3; k++) begin : g_vol_k
            cpt_mul #(
                .AW(C),
                .BW(C)
            ) u_vol_mul (
                .i_clk(i_clk),
                .i_en (en),
                .i_a  (r_crs[0][k]),
                .i_b  (r_crs[t+1][k]),
                .o_p  (w_tp[t][k])
            );
        end
    end

    // ---------------------------------------------------------------- stage 6
    logic signed [V-1:0]  r_vs [6:7][3];
    logic signed [DW-1:0] r_vtot;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < 3; t++) begin
                r_vs[6][t] <= V'(w_tp[t][0]) + V'(w_tp[t][1]) + V'(w_tp[t][2]);
                r_vs[7][t] <= r_vs[6][t];
            end
            r_vtot <= DW'(r_vs[6][VI_A]) + DW'(r_vs[6][VI_B]) + DW'(r_vs[6][VI_C]);
        end
    end

    // ---------------------------------------------------------------- stage 7
    logic       le_dot [6];
    logic       ge_dot [6];
    logic       le_vs  [3];
    logic [2:0] n_rgn7;
    logic       n_dgn7;
    logic [2:0] r_rgn [7:DSN];
    logic       r_dgn [7:DSN];

    always_comb begin
        for (int d = 0; d < 6; d++) begin
            le_dot[d] = r_dot[6][d][DT-1] || (r_dot[6][d] == '0);
            ge_dot[d] = !r_dot[6][d][DT-1];
        end
        for (int t = 0; t < 3; t++) begin
            le_vs[t] = r_vs[6][t][V-1] || (r_vs[6][t] == '0);
        end
    end

    // An edge whose two parameters are both zero has no length to divide by.
    always_comb begin
        n_rgn7 = RGN_VTX_A;
        n_dgn7 = 1'b0;
        if (le_dot[DI_SN] && le_dot[DI_TN]) begin
            n_rgn7 = RGN_VTX_A;
        end else if (le_dot[DI_SD] && le_dot[DI_UN]) begin
            n_rgn7 = RGN_VTX_B;
        end else if (le_dot[DI_TD] && le_dot[DI_UD]) begin
            n_rgn7 = RGN_VTX_C;
        end else if (le_vs[VI_C] && ge_dot[DI_SN] && ge_dot[DI_SD]) begin
            if (le_dot[DI_SN] && le_dot[DI_SD]) begin
                n_dgn7 = 1'b1;
            end else begin
                n_rgn7 = RGN_EDGE_AB;
            end
        end else if (le_vs[VI_A] && ge_dot[DI_UN] && ge_dot[DI_UD]) begin
            if (le_dot[DI_UN] && le_dot[DI_UD]) begin
                n_dgn7 = 1'b1;
            end else begin
                n_rgn7 = RGN_EDGE_BC;
            end
        end else if (le_vs[VI_B] && ge_dot[DI_TN] && ge_dot[DI_TD]) begin
            if (le_dot[DI_TN] && le_dot[DI_TD]) begin
                n_dgn7 = 1'b1;
            end else begin
                n_rgn7 = RGN_EDGE_AC;
            end
        end else begin
            n_rgn7 = RGN_INTERIOR;
        end
    end

    // ---------------------------------------------------------------- stage 8
    // Every region becomes base + (sum of x*m) / den. Vertex answers use a
    // zero numerator over one, so they ride through the divider unchanged.
    logic signed [D-1:0]  n_x [3][3];
    logic signed [V-1:0]  n_m [3];
    logic signed [DW-1:0] n_den;
    logic signed [W-1:0]  n_base [3];
    logic [2:0]           n_rgn8;
    logic                 n_dgn8;
    logic signed [D-1:0]  r_x [3][3];
    logic signed [V-1:0]  r_m [3];
    logic signed [DW-1:0] r_den [8:11];
    logic signed [W-1:0]  r_base [8:DSN][3];

    always_comb begin
        for (int t = 0; t < 3; t++) begin
            n_m[t] = '0;
            for (int k = 0; k < 3; k++) begin
                n_x[t][k] = '0;
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_base[k] = r_vtx[7][0][k];
        end
        n_den  = DW'(1);
        n_rgn8 = r_rgn[7];
        n_dgn8 = r_dgn[7];
        case (r_rgn[7])
            RGN_VTX_B: begin
                for (int k = 0; k < 3; k++) begin
                    n_base[k] = r_vtx[7][1][k];
                end
            end
            RGN_VTX_C: begin
                for (int k = 0; k < 3; k++) begin
                    n_base[k] = r_vtx[7][2][k];
                end
            end
            RGN_EDGE_AB: begin
                for (int k = 0; k < 3; k++) begin
                    n_x[0][k] = D'(r_vtx[7][1][k]) - D'(r_vtx[7][0][k]);
                end
                n_m[0] = V'(r_dot[7][DI_SN]);
                n_den  = DW'(r_dot[7][DI_SN]) + DW'(r_dot[7][DI_SD]);
            end
            RGN_EDGE_BC: begin
                for (int k = 0; k < 3; k++) begin
                    n_base[k] = r_vtx[7][1][k];
                    n_x[0][k] = D'(r_vtx[7][2][k]) - D'(r_vtx[7][1][k]);
                end
                n_m[0] = V'(r_dot[7][DI_UN]);
                n_den  = DW'(r_dot[7][DI_UN]) + DW'(r_dot[7][DI_UD]);
            end
            RGN_EDGE_AC: begin
                for (int k = 0; k < 3; k++) begin
                    n_x[0][k] = D'(r_vtx[7][2][k]) - D'(r_vtx[7][0][k]);
                end
                n_m[0] = V'(r_dot[7][DI_TN]);
                n_den  = DW'(r_dot[7][DI_TN]) + DW'(r_dot[7][DI_TD]);
            end
            RGN_INTERIOR: begin
                if (r_vtot[DW-1] || (r_vtot == '0)) begin
                    n_rgn8 = RGN_VTX_A;
                    n_dgn8 = 1'b1;
                end else begin
                    for (int t = 0; t < 3; t++) begin
                        n_m[t] = r_vs[7][t];
                        for (int k = 0; k < 3; k++) begin
                            n_x[t][k] = D'(r_vtx[7][t][k]);
                        end
                    end
                    for (int k = 0; k < 3; k++) begin
                        n_base[k] = '0;
                    end
                    n_den = r_vtot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rgn[7] <= n_rgn7;
            r_dgn[7] <= n_dgn7;
            r_rgn[8] <= n_rgn8;
            r_dgn[8] <= n_dgn8;
            for (int s = 9; s <= DSN; s++) begin
                r_rgn[s] <= r_rgn[s-1];
                r_dgn[s] <= r_dgn[s-1];
            end
            for (int t = 0; t < 3; t++) begin
                r_m[t] <= n_m[t];
                for (int k = 0; k < 3; k++) begin
                    r_x[t][k] <= n_x[t][k];
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_base[8][k] <= n_base[k];
                for (int s = 9; s <= DSN; s++) begin
                    r_base[s][k] <= r_base[s-1][k];
                end
            end
            r_den[8] <= n_den;
            for (int s = 9; s <= 11; s++) begin
                r_den[s] <= r_den[s-1];
            end
        end
    end

    // ----------------------------------------------------- stages 9 and 10
    logic signed [D+V-1:0] w_np [3][3];

    for (genvar t = 0; t < 3; t++) begin : g_num
        for (genvar k = 0; k < 3; k++) begin : g_num_k
            cpt_mul #(
                .AW(D),
                .BW(V)
            ) u_num_mul (
                .i_clk(i_clk),
                .i_en (en),
                .i_a  (r_x[t][k]),
                .i_b  (r_m[t]),
                .o_p  (w_np[t][k])
            );
        end
    end

    // --------------------------------------------------------------- stage 11
    logic signed [NW-1:0] r_num [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= NW'(w_np[0][k]) + NW'(w_np[1][k]) + NW'(w_np[2][k]);
            end
        end
    end

    // --------------------------------------------------------------- stage 12
    // Round to nearest, ties away from zero: floor((2|n| + d) / 2d).
    logic [NW-1:0]    n_mag [3];
    logic             r_neg [12:DSN][3];
    logic [RW-1:0]    r_rem [12:DSN][3];
    logic [QB-1:0]    r_q   [12:DSN][3];
    logic             r_ovf [DS0:DSN][3];
    logic [DW:0]      r_dd  [12:DSN];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r_num[k][NW-1] ? NW'(-r_num[k]) : NW'(r_num[k]);
        end
    end

    // ---------------------------------------------------- divider stages
    logic [RW-1:0] n_rem [DS0:DSN][3];
    logic [QB-1:0] n_q   [DS0:DSN][3];

    always_comb begin
        logic [RW-1:0] dsh;
        for (int s = DS0; s <= DSN; s++) begin
            for (int k = 0; k < 3; k++) begin
                dsh = RW'(r_dd[s-1]) << (DSN - s);
                if (r_rem[s-1][k] >= dsh) begin
                    n_rem[s][k] = r_rem[s-1][k] - dsh;
                    n_q[s][k]   = r_q[s-1][k] | (QB'(1) << (DSN - s));
                end else begin
                    n_rem[s][k] = r_rem[s-1][k];
                    n_q[s][k]   = r_q[s-1][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[12] <= (DW+1)'(r_den[11]) << 1;
            for (int k = 0; k < 3; k++) begin
                r_neg[12][k] <= r_num[k][NW-1];
                r_rem[12][k] <= RW'((NN'(n_mag[k]) << 1) + NN'(r_den[11]));
                r_q[12][k]   <= '0;
                r_ovf[DS0][k] <= r_rem[12][k] >= (RW'(r_dd[12]) << QB);
                for (int s = DS0; s <= DSN; s++) begin
                    r_rem[s][k] <= n_rem[s][k];
                    r_q[s][k]   <= n_q[s][k];
                    r_neg[s][k] <= r_neg[s-1][k];
                end
                for (int s = DS0 + 1; s <= DSN; s++) begin
                    r_ovf[s][k] <= r_ovf[s-1][k];
                end
            end
            for (int s = DS0; s <= DSN; s++) begin
                r_dd[s] <= r_dd[s-1];
            end
        end
    end

    // ------------------------------------------------------------ output stage
    logic [QB-1:0]        magc [3];
    logic signed [W+3:0]  mgs  [3];
    logic signed [W+3:0]  sres [3];
    logic signed [W-1:0]  qc   [3];
    t_cpt_out             n_out;
    t_cpt_out             r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_ovf[DSN][k] || (r_q[DSN][k] > QMAX)) begin
                magc[k] = QMAX;
            end else begin
                magc[k] = r_q[DSN][k];
            end
            mgs[k]  = signed'((W+4)'(magc[k]));
            sres[k] = r_neg[DSN][k] ? ((W+4)'(r_base[DSN][k]) - mgs[k])
                                    : ((W+4)'(r_base[DSN][k]) + mgs[k]);
            if (sres[k] > SAT_HI) begin
                qc[k] = SAT_HI[W-1:0];
            end else if (sres[k] < SAT_LO) begin
                qc[k] = SAT_LO[W-1:0];
            end else begin
                qc[k] = sres[k][W-1:0];
            end
        end
        n_out.qx         = qc[0];
        n_out.qy         = qc[1];
        n_out.qz         = qc[2];
        n_out.region     = r_rgn[DSN];
        n_out.degenerate = r_dgn[DSN];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== rtl/cpt_mul.sv =====
// Two-stage signed multiplier built from narrow partial products.
`default_nettype none

module cpt_mul #(
    parameter int AW = 26,
    parameter int BW = 26
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int CW = 26;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int PW = 2 * CW + 2;
    localparam int SW = (NA + NB) * CW + 2;

    logic signed [NA*CW-1:0] ae;
    logic signed [NB*CW-1:0] be;
    logic signed [CW:0]      ach [NA];
    logic signed [CW:0]      bch [NB];
    logic signed [PW-1:0]    r_pp [NA][NB];
    logic signed [SW-1:0]    acc;
    logic signed [AW+BW-1:0] r_p;

    assign ae = (NA*CW)'(i_a);
    assign be = (NB*CW)'(i_b);

    // Low chunks are unsigned; only the top chunk carries the sign.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                ach[i] = {ae[NA*CW-1], ae[i*CW +: CW]};
            end else begin
                ach[i] = {1'b0, ae[i*CW +: CW]};
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                bch[j] = {be[NB*CW-1], be[j*CW +: CW]};
            end else begin
                bch[j] = {1'b0, be[j*CW +: CW]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= ach[i] * bch[j];
                end
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (SW'(r_pp[i][j]) <<< ((i + j) * CW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= acc[AW+BW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== verif/closest_point_on_triangle_checker.sv =====
// Checker for the closest-point pipeline: predicts each result and compares it.
`timescale 1ns / 100ps

module closest_point_on_triangle_checker import cpt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     o_stall,
    input  t_cpt_in  i_item,
    input  logic     o_valid,
    input  logic     i_stall,
    input  t_cpt_out o_result,
    output int       o_errors,
    output int       o_pending,
    output int       o_checked,
    output int       o_degen_seen
);

    typedef logic signed [191:0] t_wide;
    typedef struct {
        t_wide x;
        t_wide y;
        t_wide z;
    } t_vec3;

    t_cpt_out expected_q[$];
    int       region_hits[7];

    function automatic t_vec3 vsub(t_vec3 a, t_vec3 b);
        t_vec3 r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic t_wide vdot(t_vec3 a, t_vec3 b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function automatic t_vec3 vcross(t_vec3 a, t_vec3 b);
        t_vec3 r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    // base + num/den rounded half away from zero, then saturated to CPT_W bits.
    function automatic logic signed [CPT_W-1:0] round_to_coord(t_wide base, t_wide num,
                                                               t_wide den);
        t_wide mag;
        t_wide res;
        t_wide hi;
        t_wide lo;
        mag = ((num < 0 ? -num : num) * 2 + den) / (den * 2);
        if (mag > (t_wide'(1) <<< 40)) mag = t_wide'(1) <<< 40;
        res = base + (num < 0 ? -mag : mag);
        hi = (t_wide'(1) <<< (CPT_W - 1)) - 1;
        lo = -(t_wide'(1) <<< (CPT_W - 1));
        if (res > hi) res = hi;
        if (res < lo) res = lo;
        return res[CPT_W-1:0];
    endfunction

    function automatic t_cpt_out closest_point(t_cpt_in it);
        t_vec3    a, b, c, p, ab, ac, bc, nrm, dir, start;
        t_wide    snom, sdenom, tnom, tdenom, unom, udenom, va, vb, vc, den, nom;
        t_cpt_out r;
        logic     edge_hit;
        a = '{it.ax, it.ay, it.az};
        b = '{it.bx, it.by, it.bz};
        c = '{it.cx, it.cy, it.cz};
        p = '{it.px, it.py, it.pz};
        ab = vsub(b, a);
        ac = vsub(c, a);
        bc = vsub(c, b);
        snom   = vdot(vsub(p, a), ab);
        sdenom = vdot(vsub(p, b), vsub(a, b));
        tnom   = vdot(vsub(p, a), ac);
        tdenom = vdot(vsub(p, c), vsub(a, c));
        unom   = vdot(vsub(p, b), bc);
        udenom = vdot(vsub(p, c), vsub(b, c));
        nrm = vcross(ab, ac);
        vc = vdot(nrm, vcross(vsub(a, p), vsub(b, p)));
        va = vdot(nrm, vcross(vsub(b, p), vsub(c, p)));
        vb = vdot(nrm, vcross(vsub(c, p), vsub(a, p)));
        r.qx = it.ax;
        r.qy = it.ay;
        r.qz = it.az;
        r.region = RGN_VTX_A;
        r.degenerate = 1'b0;
        edge_hit = 1'b0;
        if (snom <= 0 && tnom <= 0) begin
            r.region = RGN_VTX_A;
        end else if (sdenom <= 0 && unom <= 0) begin
            r.region = RGN_VTX_B;
            r.qx = it.bx; r.qy = it.by; r.qz = it.bz;
        end else if (tdenom <= 0 && udenom <= 0) begin
            r.region = RGN_VTX_C;
            r.qx = it.cx; r.qy = it.cy; r.qz = it.cz;
        end else if (vc <= 0 && snom >= 0 && sdenom >= 0) begin
            edge_hit = 1'b1; r.region = RGN_EDGE_AB;
            start = a; dir = ab; nom = snom; den = snom + sdenom;
        end else if (va <= 0 && unom >= 0 && udenom >= 0) begin
            edge_hit = 1'b1; r.region = RGN_EDGE_BC;
            start = b; dir = bc; nom = unom; den = unom + udenom;
        end else if (vb <= 0 && tnom >= 0 && tdenom >= 0) begin
            edge_hit = 1'b1; r.region = RGN_EDGE_AC;
            start = a; dir = ac; nom = tnom; den = tnom + tdenom;
        end else begin
            den = va + vb + vc;
            if (den <= 0) begin
                r.degenerate = 1'b1;
            end else begin
                r.region = RGN_INTERIOR;
                r.qx = round_to_coord(0, a.x * va + b.x * vb + c.x * vc, den);
                r.qy = round_to_coord(0, a.y * va + b.y * vb + c.y * vc, den);
                r.qz = round_to_coord(0, a.z * va + b.z * vb + c.z * vc, den);
            end
        end
        if (edge_hit) begin
            if (den <= 0) begin
                r.region = RGN_VTX_A;
                r.degenerate = 1'b1;
            end else begin
                r.qx = round_to_coord(start.x, dir.x * nom, den);
                r.qy = round_to_coord(start.y, dir.y * nom, den);
                r.qz = round_to_coord(start.z, dir.z * nom, den);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cpt_out want;
        if (i_rst_n && i_valid && !o_stall)
            expected_q.push_back(closest_point(i_item));
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected: %h", o_result);
                o_errors++;
            end else begin
                want = expected_q.pop_front();
                o_checked++;
                if (want.region <= RGN_INTERIOR) region_hits[want.region]++;
                if (want.degenerate) o_degen_seen++;
                if (o_result.qx !== want.qx) begin
                    $error("qx: expected %0d, got %0d", want.qx, o_result.qx);
                    o_errors++;
                end
                if (o_result.qy !== want.qy) begin
                    $error("qy: expected %0d, got %0d", want.qy, o_result.qy);
                    o_errors++;
                end
                if (o_result.qz !== want.qz) begin
                    $error("qz: expected %0d, got %0d", want.qz, o_result.qz);
                    o_errors++;
                end
                if (o_result.region !== want.region) begin
                    $error("region: expected %0d, got %0d", want.region, o_result.region);
                    o_errors++;
                end
                if (o_result.degenerate !== want.degenerate) begin
                    $error("degenerate: expected %0d, got %0d", want.degenerate,
                           o_result.degenerate);
                    o_errors++;
                end
            end
        end
        o_pending = expected_q.size();
    end

    function automatic void report_regions();
        $display("regions hit (a b c ab bc ac interior): %0d %0d %0d %0d %0d %0d %0d",
                 region_hits[0], region_hits[1], region_hits[2], region_hits[3],
                 region_hits[4], region_hits[5], region_hits[6]);
    endfunction

endmodule

// ===== verif/closest_point_on_triangle_test.sv =====
// Top of the closest-point testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module closest_point_on_triangle_test;
    import cpt_pkg::*;

    localparam int LATENCY   = CPT_W + 15;
    localparam int MAX_CYCLE = 400000;
    localparam int ONE       = 1 << 20;
    localparam int N_RANDOM  = 680;
    localparam int HOLD_AT   = 60;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_cpt_in  i_item;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_cpt_out o_result;

    int errors, pending, checked, degen_seen;
    int sender_idle_pct;
    int stall_pct;
    int hold_cycles = 0;
    logic hold_done = 1'b0;
    int cycle_count = 0;
    int sent;

    closest_point_on_triangle dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(o_result)
    );

    closest_point_on_triangle_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(o_result),
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_degen_seen(degen_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls on its own, and once holds off for a long stretch
    // while the sender keeps offering items, so the pipeline fills up.
    always @(posedge i_clk) begin
        if (!hold_done && sent >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_cycles <= 3 * LATENCY;
            i_stall     <= 1'b1;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("closest_point_on_triangle_test: errors");
            $finish;
        end
    end

    function automatic logic signed [CPT_W-1:0] rand_coord(int span);
        if (span == 0) return CPT_W'($urandom());
        return CPT_W'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic t_cpt_in make_item(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz, int px, int py, int pz);
        t_cpt_in it;
        it = '{CPT_W'(ax), CPT_W'(ay), CPT_W'(az), CPT_W'(bx), CPT_W'(by), CPT_W'(bz),
               CPT_W'(cx), CPT_W'(cy), CPT_W'(cz), CPT_W'(px), CPT_W'(py), CPT_W'(pz)};
        return it;
    endfunction

    // Half well-spread triangles of modest size, plus full-range noise,
    // collinear and repeated-vertex triangles.
    function automatic t_cpt_in random_item();
        t_cpt_in it;
        int      kind;
        int      span;
        int      k;
        kind = $urandom_range(9);
        span = (kind < 5) ? (ONE << $urandom_range(2)) : 0;
        it.ax = rand_coord(span); it.ay = rand_coord(span); it.az = rand_coord(span);
        it.bx = rand_coord(span); it.by = rand_coord(span); it.bz = rand_coord(span);
        it.cx = rand_coord(span); it.cy = rand_coord(span); it.cz = rand_coord(span);
        it.px = rand_coord(span); it.py = rand_coord(span); it.pz = rand_coord(span);
        if (kind == 7) begin
            k = $urandom_range(4) - 2;
            it.ax = rand_coord(ONE); it.ay = rand_coord(ONE); it.az = rand_coord(ONE);
            it.bx = rand_coord(ONE); it.by = rand_coord(ONE); it.bz = rand_coord(ONE);
            it.cx = CPT_W'(it.ax + k * (it.bx - it.ax));
            it.cy = CPT_W'(it.ay + k * (it.by - it.ay));
            it.cz = CPT_W'(it.az + k * (it.bz - it.az));
        end else if (kind == 8) begin
            it.bx = it.ax; it.by = it.ay; it.bz = it.az;
            if ($urandom_range(1)) begin
                it.cx = it.ax; it.cy = it.ay; it.cz = it.az;
            end
        end
        return it;
    endfunction

    task automatic offer(t_cpt_in it);
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        sent++;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            i_item  <= random_item();
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // The first edge lets the checker record the last accepted transaction.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    localparam int MX = 8388607;
    localparam int MN = -8388608;

    initial begin
        t_cpt_in directed[$];
        int      phase;
        int      n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        sender_idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unit right triangle in the xy plane, query points in every region.
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, -ONE, 0));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2*ONE, -ONE, 0));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, 2*ONE, 0));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/3, -ONE, ONE));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, -ONE));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, ONE/3, 7));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/4, ONE/3, ONE));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1, 1, -1));
        // Collinear and repeated vertices, where a zero denominator may occur.
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0, ONE/2, ONE, 0));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0, ONE, ONE, 0));
        directed.push_back(make_item(5, 5, 5, 5, 5, 5, 5, 5, 5, 9, 9, 9));
        directed.push_back(make_item(0, 0, 0, 0, 0, 0, ONE, ONE, 0, ONE/2, 0, ONE));
        directed.push_back(make_item(0, 0, 0, ONE, ONE, 0, ONE, ONE, 0, 0, ONE, 0));
        directed.push_back(make_item(0, 0, 0, ONE, 0, 0, -ONE, 0, 0, 0, ONE, 0));
        // Coordinate extremes, including near-flat triangles that push results to saturate.
        directed.push_back(make_item(MN, MN, MN, MX, MX, MX, MN, MX, MN, MX, MN, MX));
        directed.push_back(make_item(MX, MX, MX, MN, MN, MN, MX, MN, MX, MN, MX, MN));
        directed.push_back(make_item(MN, 0, 0, MX, 0, 0, 0, MX, 0, 0, 1, MN));
        directed.push_back(make_item(MX, MN, 0, MN, MX, 0, MX, MX, 1, MN, MN, MX));
        directed.push_back(make_item(MN, MN, 0, MX, MN + 1, 0, MN, MN + 1, 0, 0, 0, MX));
        directed.push_back(make_item(MX, MX, MX, MX, MX, MX, MN, MN, MN, 0, 0, 0));
        directed.push_back(make_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        foreach (directed[k]) offer(directed[k]);
        i_valid <= 1'b0;
        drain();

        for (phase = 0; phase < 4; phase++) begin
            sender_idle_pct = (phase == 1 || phase == 3) ? 68 : 0;
            stall_pct = (phase == 2) ? 68 : (phase == 3) ? 21 : 0;
            if (phase == 3) sender_idle_pct = 21;
            for (n = 0; n < N_RANDOM / 4; n++) begin
                offer(random_item());
            end
            i_valid <= 1'b0;
            drain();
        end

        $display("sent %0d transactions, checked %0d results, %0d degenerate", sent,
                 checked, degen_seen);
        checker_inst.report_regions();
        if (errors == 0 && pending == 0 && checked == sent) begin
            $display("closest_point_on_triangle_test: clean");
        end else begin
            $display("closest_point_on_triangle_test: errors");
        end
        $finish;
    end

endmodule

// ===== closest_point_on_triangle.f =====
rtl/cpt_pkg.sv
rtl/cpt_mul.sv
rtl/closest_point_on_triangle.sv
verif/closest_point_on_triangle_checker.sv
verif/closest_point_on_triangle_test.sv
